>>> sv/vdl_pkg.sv
// ----------------------------------------------------------------------------
// vdl_pkg
// Shared widths, types and codes for the L1/L2 vector distance block.
// ----------------------------------------------------------------------------
package vdl_pkg;

    localparam int FEATURE_BITS = 16;
    localparam int SUM_BITS     = 44;
    localparam int DIST_BITS    = 26;
    localparam int DIFF_BITS    = FEATURE_BITS + 1;
    localparam int SQ_IN_BITS   = (DIFF_BITS < SUM_BITS / 2) ? DIFF_BITS : SUM_BITS / 2;
    localparam int ADD_BITS     = (2 * SQ_IN_BITS > DIFF_BITS) ? 2 * SQ_IN_BITS : DIFF_BITS;
    localparam int ROOT_STEPS   = SUM_BITS / 2;
    localparam int ROOT_CNT_BITS = $clog2(ROOT_STEPS);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int S_TDATA_BITS = ((2 * FEATURE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((DIST_BITS + 7) / 8) * 8;

    localparam logic [SUM_BITS-1:0] SUM_MAX  = {SUM_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0] DIST_MAX = SUM_BITS'({DIST_BITS{1'b1}});

    typedef enum logic {
        METRIC_EUCLID    = 1'b0,
        METRIC_MANHATTAN = 1'b1
    } metric_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ROOT,
        B_FIN
    } back_state_t;

    // one finished vector, front to back
    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic                ovf;
        metric_t             metric;
    } vec_entry_t;

    typedef struct packed {
        logic       push;
        vec_entry_t entry;
    } queue_wr_t;

endpackage

>>> sv/vector_distance_l1_l2.sv
// ----------------------------------------------------------------------------
// vector_distance_l1_l2
// Euclidean / Manhattan distance between a point and a centroid, one
// coordinate pair per item, one result item per vector.
// ----------------------------------------------------------------------------
// Throughput: one pair per cycle while s_tready is high; a last pair waits while
// the queue is full. The back part takes one vector at a time, Euclidean ones
// through the 22-step bit-serial square root. A pair passes the absolute
// difference, value to add and running sum stages, then the queue and back part.
// A held result (m_tready low) stalls the back part and then fills the queue.
// Synchronous active-low reset clears the sum, flag, queue and metric.
module vector_distance_l1_l2 (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data,  // metric
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [vdl_pkg::S_TDATA_BITS-1:0]   s_tdata,  // point_value, centroid_value
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vdl_pkg::M_TDATA_BITS-1:0]   m_tdata,  // distance, zero pad
    output logic [0:0]                         m_tuser   // saturated
);
    import vdl_pkg::*;

    metric_t              metric_reg;
    queue_wr_t            q_wr;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    vec_entry_t           q_entry;
    logic [DIST_BITS-1:0] distance;
    logic                 saturated;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            metric_reg <= METRIC_EUCLID;
        end else if (cfg_wr_en) begin
            metric_reg <= metric_t'(cfg_wr_data);
        end
    end

    vdl_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .metric         (metric_reg),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .point_value    (s_tdata[FEATURE_BITS-1:0]),
        .centroid_value (s_tdata[2*FEATURE_BITS-1:FEATURE_BITS]),
        .last_pair      (s_tlast),
        .q_wr           (q_wr),
        .q_full         (q_full)
    );

    vdl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (q_wr),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_entry (q_entry)
    );

    vdl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .distance  (distance),
        .saturated (saturated)
    );

    assign m_tdata = M_TDATA_BITS'(distance);
    assign m_tuser = saturated;

endmodule

>>> sv/vdl_queue.sv
// ----------------------------------------------------------------------------
// vdl_queue
// Short queue of finished vector sums between the front and back parts.
// ----------------------------------------------------------------------------
module vdl_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  vdl_pkg::queue_wr_t  wr,
    output logic                full,
    input  logic                pop,
    output logic                rd_valid,
    output vdl_pkg::vec_entry_t rd_entry
);
    import vdl_pkg::*;

    vec_entry_t                mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   cnt_reg, cnt_next;
    logic                      do_push;
    logic                      do_pop;

    assign full     = (cnt_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_entry = mem[rd_ptr_reg];
    assign do_push  = wr.push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr.entry;
        end
    end

endmodule

>>> sv/vdl_front.sv
// ----------------------------------------------------------------------------
// vdl_front
// Accepts coordinate pairs, forms |p - c| or its square and keeps the
// saturating running sum; pushes one entry per vector on the last pair.
// ----------------------------------------------------------------------------
module vdl_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  vdl_pkg::metric_t                  metric,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic signed [vdl_pkg::FEATURE_BITS-1:0] point_value,
    input  logic signed [vdl_pkg::FEATURE_BITS-1:0] centroid_value,
    input  logic                              last_pair,
    output vdl_pkg::queue_wr_t                q_wr,
    input  logic                              q_full
);
    import vdl_pkg::*;

    logic                  adv;
    logic signed [DIFF_BITS-1:0] diff;
    logic [DIFF_BITS-1:0]  abs_diff;

    // stage 1: absolute difference
    logic                  s1_valid_reg;
    logic                  s1_last_reg;
    metric_t               s1_metric_reg;
    logic [DIFF_BITS-1:0]  s1_abs_reg;
    logic                  s1_big_reg;

    // stage 2: value to add
    logic                  s2_valid_reg;
    logic                  s2_last_reg;
    metric_t               s2_metric_reg;
    logic [ADD_BITS-1:0]   s2_add_reg;
    logic                  s2_big_reg;
    logic [ADD_BITS-1:0]   add_next;
    logic [SQ_IN_BITS-1:0] sq_in;
    logic [2*SQ_IN_BITS-1:0] sq_prod;

    // stage 3: running sum
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic                  ovf_reg, ovf_next;
    logic [SUM_BITS:0]     sum_wide;
    logic [SUM_BITS-1:0]   sum_upd;
    logic                  ovf_upd;

    assign adv      = !(s2_valid_reg && s2_last_reg && q_full);
    assign s_tready = adv;

    assign diff     = DIFF_BITS'(point_value) - DIFF_BITS'(centroid_value);
    assign abs_diff = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);

    assign sq_in    = s1_abs_reg[SQ_IN_BITS-1:0];
    assign sq_prod  = sq_in * sq_in;
    assign add_next = (s1_metric_reg == METRIC_MANHATTAN) ? ADD_BITS'(s1_abs_reg)
                                                          : ADD_BITS'(sq_prod);

    assign sum_wide = (SUM_BITS+1)'(sum_reg) + (SUM_BITS+1)'(s2_add_reg);

    always_comb begin
        sum_upd = sum_reg;
        ovf_upd = ovf_reg;
        if (s2_big_reg || sum_wide[SUM_BITS]) begin
            sum_upd = SUM_MAX;
            ovf_upd = 1'b1;
        end else begin
            sum_upd = sum_wide[SUM_BITS-1:0];
        end
    end

    always_comb begin
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        q_wr.push      = 1'b0;
        q_wr.entry.sum    = sum_upd;
        q_wr.entry.ovf    = ovf_upd;
        q_wr.entry.metric = s2_metric_reg;
        if (adv && s2_valid_reg) begin
            if (s2_last_reg) begin
                q_wr.push = 1'b1;
                sum_next  = '0;
                ovf_next  = 1'b0;
            end else begin
                sum_next  = sum_upd;
                ovf_next  = ovf_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sum_reg      <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            sum_reg <= sum_next;
            ovf_reg <= ovf_next;
            if (adv) begin
                s1_valid_reg <= s_tvalid;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_last_reg   <= last_pair;
            s1_metric_reg <= metric;
            s1_abs_reg    <= abs_diff;
            s1_big_reg    <= (metric == METRIC_EUCLID) && ((abs_diff >> SQ_IN_BITS) != '0);
            s2_last_reg   <= s1_last_reg;
            s2_metric_reg <= s1_metric_reg;
            s2_add_reg    <= add_next;
            s2_big_reg    <= s1_big_reg;
        end
    end

endmodule

>>> sv/vdl_back.sv
// ----------------------------------------------------------------------------
// vdl_back
// Takes finished sums from the queue, runs the bit-serial square root for
// the Euclidean metric, clamps to the output width and holds the result.
// ----------------------------------------------------------------------------
module vdl_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  vdl_pkg::vec_entry_t                 q_entry,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [vdl_pkg::DIST_BITS-1:0]       distance,
    output logic                                saturated
);
    import vdl_pkg::*;

    back_state_t              state_reg, state_next;
    logic [SUM_BITS-1:0]      x_reg, x_next;
    logic [SUM_BITS-1:0]      res_reg, res_next;
    logic [SUM_BITS-1:0]      bit_reg, bit_next;
    logic [ROOT_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                     ovf_reg, ovf_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DIST_BITS-1:0]     dist_reg, dist_next;
    logic                     sat_reg, sat_next;
    logic [SUM_BITS:0]        trial;
    logic                     out_free;

    assign out_free  = !out_valid_reg || m_tready;
    assign trial     = (SUM_BITS+1)'(res_reg) + (SUM_BITS+1)'(bit_reg);
    assign m_tvalid  = out_valid_reg;
    assign distance  = dist_reg;
    assign saturated = sat_reg;

    always_comb begin
        state_next     = state_reg;
        x_next         = x_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        dist_next      = dist_reg;
        sat_next       = sat_reg;
        pop            = 1'b0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    pop      = 1'b1;
                    ovf_next = q_entry.ovf;
                    x_next   = q_entry.sum;
                    bit_next = SUM_BITS'(1) << (SUM_BITS - 2);
                    cnt_next = ROOT_CNT_BITS'(ROOT_STEPS - 1);
                    if (q_entry.metric == METRIC_MANHATTAN) begin
                        res_next   = q_entry.sum;
                        state_next = B_FIN;
                    end else begin
                        res_next   = '0;
                        state_next = B_ROOT;
                    end
                end
            end
            B_ROOT: begin
                if ((SUM_BITS+1)'(x_reg) >= trial) begin
                    x_next   = x_reg - trial[SUM_BITS-1:0];
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = B_FIN;
                end
            end
            B_FIN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (res_reg > DIST_MAX) begin
                        dist_next = {DIST_BITS{1'b1}};
                        sat_next  = 1'b1;
                    end else begin
                        dist_next = res_reg[DIST_BITS-1:0];
                        sat_next  = ovf_reg;
                    end
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        cnt_reg  <= cnt_next;
        ovf_reg  <= ovf_next;
        dist_reg <= dist_next;
        sat_reg  <= sat_next;
    end

    a_pop_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("pop from empty queue");

    a_root_counts_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_ROOT && cnt_reg != '0) |=>
            (state_reg == B_ROOT && cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("root step count broken");

    a_root_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_ROOT && cnt_reg == '0) |=> (state_reg == B_FIN))
        else $error("root did not finish");

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_FIN && out_valid_reg && !m_tready) |=> (state_reg == B_FIN))
        else $error("result overwrote a pending item");

endmodule
